// File: sv/gdt_pkg.sv
package gdt_pkg;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int MINS_PER_HOUR = 60;
  localparam int MONTHS_PER_YEAR = 12;

  localparam logic [15:0] DOY_HUNDREDS_MASK = 16'hf000;
  localparam logic [15:0] DOY_TENS_MASK = 16'h0f00;
  localparam logic [15:0] DOY_UNITS_MASK = 16'h00f0;
  localparam logic [15:0] YEAR_UNITS_MASK = 16'h000f;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [10:0] day;
  } date_t;

  // Days in the year before the start of month idx + 1. The leap table is
  // the common table plus one from March on.
  function automatic logic [10:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [10:0] base;
    case (idx)
      4'd0: base = 11'd0;
      4'd1: base = 11'd31;
      4'd2: base = 11'd59;
      4'd3: base = 11'd90;
      4'd4: base = 11'd120;
      4'd5: base = 11'd151;
      4'd6: base = 11'd181;
      4'd7: base = 11'd212;
      4'd8: base = 11'd243;
      4'd9: base = 11'd273;
      4'd10: base = 11'd304;
      4'd11: base = 11'd334;
      4'd12: base = 11'd365;
      default: base = 11'd365;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 11'd1;
    end
    return base;
  endfunction

endpackage

// File: sv/gps_date_time_decode.sv
// Decodes one GPS time record per word into hour, minute and second of the
// UTC day, a two-digit year, and the month and day of month taken from the
// BCD day of year (month 13 marks a day past the end of the year). A word
// is held in an input register, decoded in one pass of logic and placed in
// an output register. One word can be taken every cycle; throughput drops
// only while out_stall holds a result in the output register and the input
// register is also full.
module gps_date_time_decode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] in_seconds_of_day,
  input  logic [15:0] in_doy_word,
  input  logic [15:0] in_year_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out,
  output logic [7:0]  out_year_out,
  output logic [3:0]  out_month_out,
  output logic [10:0] out_day_out
);
  import gdt_pkg::*;

  logic        in_vld_r;
  logic        in_vld_nxt;
  logic [16:0] secs_r;
  logic [15:0] doy_word_r;
  logic [15:0] year_word_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  tod_t        tod_r;
  date_t       date_r;
  tod_t        tod;
  date_t       date;
  logic        out_free;
  logic        in_take;
  logic        advance;

  gdt_time u_time (
    .seconds_of_day(secs_r),
    .tod           (tod)
  );

  gdt_date u_date (
    .doy_word (doy_word_r),
    .year_word(year_word_r),
    .date     (date)
  );

  always_comb begin
    out_free = !out_vld_r || !out_stall;
    advance = in_vld_r && out_free;
    in_stall = in_vld_r && !out_free;
    in_take = in_valid && !in_stall;
    in_vld_nxt = in_stall ? in_vld_r : in_valid;
    out_vld_nxt = out_free ? in_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      secs_r <= in_seconds_of_day;
      doy_word_r <= in_doy_word;
      year_word_r <= in_year_word;
    end
    if (advance) begin
      tod_r <= tod;
      date_r <= date;
    end
  end

  assign out_valid = out_vld_r;
  assign out_hour_out = tod_r.hour;
  assign out_minute_out = tod_r.minute;
  assign out_second_out = tod_r.second;
  assign out_year_out = date_r.year;
  assign out_month_out = date_r.month;
  assign out_day_out = date_r.day;

endmodule

// File: sv/gdt_time.sv
module gdt_time (
  input  logic [16:0]   seconds_of_day,
  output gdt_pkg::tod_t tod
);
  import gdt_pkg::*;

  logic [16:0] secs;
  logic [16:0] hour_base;
  logic [11:0] rem_h;
  logic [11:0] min_base;
  logic [4:0]  hour;
  logic [5:0]  minute;

  always_comb begin
    secs = (seconds_of_day >= SECS_PER_DAY) ? (seconds_of_day - SECS_PER_DAY)
                                            : seconds_of_day;
    hour = '0;
    hour_base = '0;
    for (int k = 1; k < HOURS_PER_DAY; k++) begin
      if (secs >= 17'(k * SECS_PER_HOUR)) begin
        hour = 5'(k);
        hour_base = 17'(k * SECS_PER_HOUR);
      end
    end
    rem_h = 12'(secs - hour_base);

    minute = '0;
    min_base = '0;
    for (int k = 1; k < MINS_PER_HOUR; k++) begin
      if (rem_h >= 12'(k * SECS_PER_MIN)) begin
        minute = 6'(k);
        min_base = 12'(k * SECS_PER_MIN);
      end
    end

    tod.hour = hour;
    tod.minute = minute;
    tod.second = 6'(rem_h - min_base);
  end

endmodule

// File: sv/gdt_date.sv
module gdt_date (
  input  logic [15:0]    doy_word,
  input  logic [15:0]    year_word,
  output gdt_pkg::date_t date
);
  import gdt_pkg::*;

  logic [3:0]  doy_h;
  logic [3:0]  doy_t;
  logic [3:0]  doy_u;
  logic [3:0]  yr_u;
  logic [10:0] doy;
  logic [7:0]  year;
  logic        leap;
  logic [3:0]  month;

  always_comb begin
    doy_h = 4'((doy_word & DOY_HUNDREDS_MASK) >> 12);
    doy_t = 4'((doy_word & DOY_TENS_MASK) >> 8);
    doy_u = 4'((doy_word & DOY_UNITS_MASK) >> 4);
    yr_u = 4'(year_word & YEAR_UNITS_MASK);

    doy = 11'(doy_h) * 11'd100 + 11'(doy_t) * 11'd10 + 11'(doy_u);
    year = 8'(year_word[7:4]) * 8'd10 + 8'(yr_u);
    leap = (year[1:0] == 2'b00);

    // The table rises monotonically, so the last threshold passed gives the month.
    month = 4'd1;
    for (int m = 1; m <= MONTHS_PER_YEAR; m++) begin
      if (doy > cum_days(leap, 4'(m))) begin
        month = 4'(m + 1);
      end
    end

    date.year = year;
    date.month = month;
    date.day = doy - cum_days(leap, month - 4'd1);
  end

endmodule

// File: sv/gdt_checker.sv
module gdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_hour_out,
  input logic [5:0]  out_minute_out,
  input logic [5:0]  out_second_out,
  input logic [7:0]  out_year_out,
  input logic [3:0]  out_month_out,
  input logic [10:0] out_day_out
);

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hour_out)
      && $stable(out_minute_out) && $stable(out_second_out) && $stable(out_year_out)
      && $stable(out_month_out) && $stable(out_day_out))
    else $error("stalled result changed");

  // An accepted word reaches the output once the output side moves.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_out <= 5'd23) && (out_minute_out <= 6'd59)
      && (out_second_out <= 6'd59))
    else $error("time of day out of range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_out >= 4'd1) && (out_month_out <= 4'd13)
      && (out_year_out <= 8'd165))
    else $error("month or year out of range");

endmodule

bind gps_date_time_decode gdt_checker u_gdt_checker (.*);
